>>> rtl/core/rbeo_pkg.sv
// rbeo_pkg: shared types and constants for the request slot ring with oldest eviction
// used by rbeo_cell and ring_buffer_evict_oldest_core; no dependencies
`default_nettype none

package rbeo_pkg;

  // default configuration
  localparam int NUM_SLOTS_DEF = 8;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths of the ports
  localparam int ID_W       = 16;
  localparam int PORT_TIME_W = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 3;

  // operation codes carried by the mode field
  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_TAKE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_state_t;

  // broadcast control from the controller to every cell
  typedef struct packed {
    logic mode;     // operation of the item in flight
    logic wr_en;    // commit a write this cycle
    logic wr_valid; // new occupied flag of the written slot
    logic wr_data;  // also overwrite id and time
  } cell_ctrl_t;

  // flags carried by the probe along the chain
  typedef struct packed {
    logic found;  // a matching slot has been seen
    logic sel_hi; // the selected slot sits at or after the pointer
  } probe_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/rbeo_cell.sv
// rbeo_cell: one slot of the ring plus one stage of the scan probe
// depends on rbeo_pkg
`default_nettype none

module rbeo_cell #(
  parameter int NUM_SLOTS = rbeo_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = rbeo_pkg::TIME_BITS_DEF,
  parameter int CELL_IDX  = 0,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  rbeo_pkg::cell_ctrl_t   ctrl_i,
  input  wire  [IDX_W-1:0]             ptr_i,
  input  wire  [IDX_W-1:0]             wr_idx_i,
  input  wire  [rbeo_pkg::ID_W-1:0]    wr_id_i,
  input  wire  [TIME_BITS-1:0]         wr_time_i,
  input  wire  rbeo_pkg::probe_flags_t flg_i,
  input  wire  [IDX_W-1:0]             sel_idx_i,
  input  wire  [rbeo_pkg::ID_W-1:0]    sel_id_i,
  input  wire  [TIME_BITS-1:0]         sel_time_i,
  input  wire  [IDX_W-1:0]             min_idx_i,
  input  wire  [rbeo_pkg::ID_W-1:0]    min_id_i,
  input  wire  [TIME_BITS-1:0]         min_time_i,
  input  wire  [CNT_W-1:0]             cnt_i,
  output rbeo_pkg::probe_flags_t       flg_o,
  output logic [IDX_W-1:0]             sel_idx_o,
  output logic [rbeo_pkg::ID_W-1:0]    sel_id_o,
  output logic [TIME_BITS-1:0]         sel_time_o,
  output logic [IDX_W-1:0]             min_idx_o,
  output logic [rbeo_pkg::ID_W-1:0]    min_id_o,
  output logic [TIME_BITS-1:0]         min_time_o,
  output logic [CNT_W-1:0]             cnt_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // slot contents
  logic                      valid_r;
  logic [rbeo_pkg::ID_W-1:0] id_r;
  logic [TIME_BITS-1:0]      time_r;

  logic hit;
  logic is_hi;
  logic sel_take;
  logic min_take;
  logic my_wr;

  rbeo_pkg::probe_flags_t    flg_nxt;
  logic [IDX_W-1:0]          sel_idx_nxt;
  logic [rbeo_pkg::ID_W-1:0] sel_id_nxt;
  logic [TIME_BITS-1:0]      sel_time_nxt;
  logic [IDX_W-1:0]          min_idx_nxt;
  logic [rbeo_pkg::ID_W-1:0] min_id_nxt;
  logic [TIME_BITS-1:0]      min_time_nxt;
  logic [CNT_W-1:0]          cnt_nxt;

  // slot write from the controller
  assign my_wr = ctrl_i.wr_en && (wr_idx_i == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (my_wr) begin
      valid_r <= ctrl_i.wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (my_wr && ctrl_i.wr_data) begin
      id_r   <= wr_id_i;
      time_r <= wr_time_i;
    end
  end

  // place looks for a free slot, take for an occupied one
  assign hit   = (ctrl_i.mode == rbeo_pkg::MODE_TAKE) ? valid_r : !valid_r;
  assign is_hi = (MY_IDX >= ptr_i);

  // first hit at or after the pointer wins, else first hit overall
  assign sel_take = hit && (!flg_i.found || (!flg_i.sel_hi && is_hi));
  // strict compare keeps the lowest index on ties
  assign min_take = (CELL_IDX == 0) || (time_r < min_time_i);

  always_comb begin
    flg_nxt      = flg_i;
    sel_idx_nxt  = sel_idx_i;
    sel_id_nxt   = sel_id_i;
    sel_time_nxt = sel_time_i;
    if (sel_take) begin
      flg_nxt.found  = 1'b1;
      flg_nxt.sel_hi = is_hi;
      sel_idx_nxt    = MY_IDX;
      sel_id_nxt     = id_r;
      sel_time_nxt   = time_r;
    end
    min_idx_nxt  = min_take ? MY_IDX : min_idx_i;
    min_id_nxt   = min_take ? id_r   : min_id_i;
    min_time_nxt = min_take ? time_r : min_time_i;
    cnt_nxt      = cnt_i + CNT_W'(valid_r);
  end

  // probe stage register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_o <= '0;
      cnt_o <= '0;
    end else begin
      flg_o <= flg_nxt;
      cnt_o <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_idx_o  <= sel_idx_nxt;
    sel_id_o   <= sel_id_nxt;
    sel_time_o <= sel_time_nxt;
    min_idx_o  <= min_idx_nxt;
    min_id_o   <= min_id_nxt;
    min_time_o <= min_time_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/ring_buffer_evict_oldest_core.sv
// ring_buffer_evict_oldest_core: top level, controller and chain of slot cells
// depends on rbeo_pkg and rbeo_cell
//
// Usage:
//  - input channel (in_valid/in_ready): one beat is one operation; in_mode 0
//    places in_request_id with in_creation_time, in_mode 1 takes a request.
//  - result channel (out_valid/out_ready): exactly one result beat per input
//    beat, in order, with status, id, time, slot index and full/empty flags.
//  - a probe walks the chain of NUM_SLOTS cells one cell per cycle, picking
//    up the free/occupied slot search, the oldest timestamp and the fill
//    count; the controller then commits the write and loads the result.
//  - the result register is loaded by the commit in DONE, after SCAN.
//  - one operation at a time: in_ready is high only in IDLE, so a beat waits
//    for the probe's walk through the chain and the commit of the last one.
//  - reset: all slots free, both pointers at slot zero, no result pending.
//  - a stalled receiver holds the result register; the next input beat is
//    still accepted and scanned, and its commit waits until the register
//    drains.
`default_nettype none

module ring_buffer_evict_oldest_core #(
  parameter int NUM_SLOTS = rbeo_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = rbeo_pkg::TIME_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_mode,
  input  wire  [rbeo_pkg::ID_W-1:0]            in_request_id,
  input  wire  [rbeo_pkg::PORT_TIME_W-1:0]     in_creation_time,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [rbeo_pkg::STATUS_W-1:0]        out_status,
  output logic [rbeo_pkg::ID_W-1:0]            out_request_id,
  output logic [rbeo_pkg::PORT_TIME_W-1:0]     out_creation_time,
  output logic [rbeo_pkg::SLOT_IDX_W-1:0]      out_slot_index,
  output logic                                 out_now_full,
  output logic                                 out_now_empty
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);

  // controller state
  rbeo_pkg::fsm_state_t state_r, state_nxt;
  logic [IDX_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0] place_ptr_r, take_ptr_r;

  // item in flight
  logic                      mode_r;
  logic [rbeo_pkg::ID_W-1:0] id_r;
  logic [TIME_BITS-1:0]      time_r;

  // result register
  logic                                 out_valid_r;
  logic [rbeo_pkg::STATUS_W-1:0]        out_status_r;
  logic [rbeo_pkg::ID_W-1:0]            out_id_r;
  logic [rbeo_pkg::PORT_TIME_W-1:0]     out_time_r;
  logic [rbeo_pkg::SLOT_IDX_W-1:0]      out_idx_r;
  logic                                 out_full_r;
  logic                                 out_empty_r;

  logic in_fire;
  logic out_free;
  logic commit;

  rbeo_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]     ptr;
  logic [IDX_W-1:0]     wr_idx;

  // probe chain taps, index k feeds cell k
  rbeo_pkg::probe_flags_t    flg_c      [NUM_SLOTS+1];
  logic [IDX_W-1:0]          sel_idx_c  [NUM_SLOTS+1];
  logic [rbeo_pkg::ID_W-1:0] sel_id_c   [NUM_SLOTS+1];
  logic [TIME_BITS-1:0]      sel_time_c [NUM_SLOTS+1];
  logic [IDX_W-1:0]          min_idx_c  [NUM_SLOTS+1];
  logic [rbeo_pkg::ID_W-1:0] min_id_c   [NUM_SLOTS+1];
  logic [TIME_BITS-1:0]      min_time_c [NUM_SLOTS+1];
  logic [CNT_W-1:0]          cnt_c      [NUM_SLOTS+1];

  // decisions at the end of the scan
  logic [CNT_W-1:0]              p_cnt;
  logic                          p_full;
  logic                          p_empty;
  logic                          do_wr;
  logic                          do_wr_valid;
  logic                          do_wr_data;
  logic [rbeo_pkg::STATUS_W-1:0] res_status;
  logic [rbeo_pkg::ID_W-1:0]     res_id;
  logic [TIME_BITS-1:0]          res_time;
  logic [IDX_W-1:0]              res_idx;
  logic [CNT_W-1:0]              cnt_after;
  logic                          adv_place;
  logic                          adv_take;
  logic [IDX_W-1:0]              next_idx;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbeo_pkg::S_IDLE: if (in_valid) state_nxt = rbeo_pkg::S_SCAN;
      rbeo_pkg::S_SCAN: if (scan_cnt_r == LAST_IDX) state_nxt = rbeo_pkg::S_DONE;
      rbeo_pkg::S_DONE: if (out_free) state_nxt = rbeo_pkg::S_IDLE;
      default:          state_nxt = rbeo_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      rbeo_pkg::S_IDLE: in_ready = 1'b1;
      rbeo_pkg::S_SCAN: in_ready = 1'b0;
      rbeo_pkg::S_DONE: commit   = out_free;
      default:          in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbeo_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan counter, one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (in_fire) begin
      scan_cnt_r <= '0;
    end else if (state_r == rbeo_pkg::S_SCAN) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rbeo_pkg::MODE_PLACE;
    end else if (in_fire) begin
      mode_r <= in_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r   <= in_request_id;
      time_r <= TIME_BITS'(in_creation_time);
    end
  end

  // probe entering cell zero
  assign flg_c[0]      = '0;
  assign sel_idx_c[0]  = '0;
  assign sel_id_c[0]   = '0;
  assign sel_time_c[0] = '0;
  assign min_idx_c[0]  = '0;
  assign min_id_c[0]   = '0;
  assign min_time_c[0] = '0;
  assign cnt_c[0]      = '0;

  assign ptr = (mode_r == rbeo_pkg::MODE_TAKE) ? take_ptr_r : place_ptr_r;

  assign ctrl.mode     = mode_r;
  assign ctrl.wr_en    = commit && do_wr;
  assign ctrl.wr_valid = do_wr_valid;
  assign ctrl.wr_data  = do_wr_data;
  assign wr_idx        = res_idx;

  // chain of slot cells
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    rbeo_cell #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .ptr_i      (ptr),
      .wr_idx_i   (wr_idx),
      .wr_id_i    (id_r),
      .wr_time_i  (time_r),
      .flg_i      (flg_c[k]),
      .sel_idx_i  (sel_idx_c[k]),
      .sel_id_i   (sel_id_c[k]),
      .sel_time_i (sel_time_c[k]),
      .min_idx_i  (min_idx_c[k]),
      .min_id_i   (min_id_c[k]),
      .min_time_i (min_time_c[k]),
      .cnt_i      (cnt_c[k]),
      .flg_o      (flg_c[k+1]),
      .sel_idx_o  (sel_idx_c[k+1]),
      .sel_id_o   (sel_id_c[k+1]),
      .sel_time_o (sel_time_c[k+1]),
      .min_idx_o  (min_idx_c[k+1]),
      .min_id_o   (min_id_c[k+1]),
      .min_time_o (min_time_c[k+1]),
      .cnt_o      (cnt_c[k+1])
    );
  end

  // probe leaving the last cell
  assign p_cnt   = cnt_c[NUM_SLOTS];
  assign p_full  = (p_cnt == FULL_CNT);
  assign p_empty = (p_cnt == '0);

  // operation outcome
  always_comb begin
    do_wr       = 1'b0;
    do_wr_valid = 1'b0;
    do_wr_data  = 1'b0;
    res_status  = rbeo_pkg::ST_EMPTY;
    res_id      = '0;
    res_time    = '0;
    res_idx     = '0;
    cnt_after   = p_cnt;
    adv_place   = 1'b0;
    adv_take    = 1'b0;
    if (mode_r == rbeo_pkg::MODE_PLACE) begin
      do_wr       = 1'b1;
      do_wr_valid = 1'b1;
      do_wr_data  = 1'b1;
      if (!p_full) begin
        res_status = rbeo_pkg::ST_PLACED;
        res_idx    = sel_idx_c[NUM_SLOTS];
        cnt_after  = p_cnt + 1'b1;
        adv_place  = 1'b1;
      end else begin
        res_status = rbeo_pkg::ST_EVICTED;
        res_id     = min_id_c[NUM_SLOTS];
        res_time   = min_time_c[NUM_SLOTS];
        res_idx    = min_idx_c[NUM_SLOTS];
      end
    end else if (!p_empty) begin
      do_wr      = 1'b1;
      res_status = rbeo_pkg::ST_TAKEN;
      res_id     = sel_id_c[NUM_SLOTS];
      res_time   = sel_time_c[NUM_SLOTS];
      res_idx    = sel_idx_c[NUM_SLOTS];
      cnt_after  = p_cnt - 1'b1;
      adv_take   = 1'b1;
    end
  end

  assign next_idx = (res_idx == LAST_IDX) ? '0 : res_idx + 1'b1;

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_ptr_r <= '0;
      take_ptr_r  <= '0;
    end else if (commit) begin
      if (adv_place) place_ptr_r <= next_idx;
      if (adv_take)  take_ptr_r  <= next_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_time_r   <= rbeo_pkg::PORT_TIME_W'(res_time);
      out_idx_r    <= rbeo_pkg::SLOT_IDX_W'(res_idx);
      out_full_r   <= (cnt_after == FULL_CNT);
      out_empty_r  <= (cnt_after == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_request_id    = out_id_r;
  assign out_creation_time = out_time_r;
  assign out_slot_index    = out_idx_r;
  assign out_now_full      = out_full_r;
  assign out_now_empty     = out_empty_r;

  // a commit always leaves a result beat behind
  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit did not load the result register");

  // an eviction only happens on a full ring, which stays full
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == rbeo_pkg::ST_EVICTED) |-> out_full_r)
    else $error("eviction reported on a ring that is not full");

  // take on an empty ring leaves it empty
  a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == rbeo_pkg::ST_EMPTY) |-> out_empty_r)
    else $error("empty take reported with occupied slots");

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (place_ptr_r <= LAST_IDX) && (take_ptr_r <= LAST_IDX))
    else $error("slot pointer beyond the last slot");

  // the fill count out of the chain never exceeds the slot count
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbeo_pkg::S_DONE) |-> (p_cnt <= FULL_CNT))
    else $error("fill count beyond the slot count");

endmodule

`default_nettype wire

>>> dv/tb.sv
// tb: self-checking bench for ring_buffer_evict_oldest_core, with a scoreboard
// class that predicts place, evict and take results; plain tasks drive the beats
// depends on rbeo_pkg and ring_buffer_evict_oldest_core
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = rbeo_pkg::NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_BEATS  = 500;
  localparam int ID_W        = rbeo_pkg::ID_W;
  localparam int TM_W        = rbeo_pkg::PORT_TIME_W;
  localparam int ST_W        = rbeo_pkg::STATUS_W;
  localparam int IX_W        = rbeo_pkg::SLOT_IDX_W;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] request_id;
    logic [TM_W-1:0] creation_time;
    logic [IX_W-1:0] slot_index;
    logic            now_full;
    logic            now_empty;
  } ring_result_t;

  // slot ring mirror plus the queue of results still owed by the block
  class request_ring_board;
    logic            occupied[SLOTS];
    logic [ID_W-1:0] slot_ids[SLOTS];
    logic [TM_W-1:0] slot_stamps[SLOTS];
    int unsigned     place_ptr;
    int unsigned     take_ptr;
    ring_result_t    pending_results[$];
    int unsigned     error_count;

    function new();
      for (int k = 0; k < SLOTS; k++) begin
        occupied[k] = 1'b0;
        slot_ids[k] = '0;
        slot_stamps[k] = '0;
      end
      place_ptr = 0;
      take_ptr = 0;
      error_count = 0;
    endfunction

    function int unsigned fill_level();
      int unsigned n;
      n = 0;
      for (int k = 0; k < SLOTS; k++) if (occupied[k]) n++;
      return n;
    endfunction

    // work out the result of one accepted operation and update the mirror
    function void note_beat(input logic mode, input logic [ID_W-1:0] id,
                            input logic [TM_W-1:0] stamp);
      ring_result_t r;
      int unsigned  fill;
      int unsigned  s;
      r = '0;
      fill = fill_level();
      if (mode == rbeo_pkg::MODE_PLACE) begin
        if (fill < SLOTS) begin
          // first free slot at or after the place pointer
          s = place_ptr;
          for (int k = 0; k < SLOTS && occupied[s]; k++) s = (s + 1) % SLOTS;
          occupied[s] = 1'b1;
          slot_ids[s] = id;
          slot_stamps[s] = stamp;
          place_ptr = (s + 1) % SLOTS;
          r.status = rbeo_pkg::ST_PLACED;
        end else begin
          // full: oldest stamp goes, lowest index wins ties, pointer stays
          s = 0;
          for (int k = 1; k < SLOTS; k++) if (slot_stamps[k] < slot_stamps[s]) s = k;
          r.status = rbeo_pkg::ST_EVICTED;
          r.request_id = slot_ids[s];
          r.creation_time = slot_stamps[s];
          slot_ids[s] = id;
          slot_stamps[s] = stamp;
        end
        r.slot_index = IX_W'(s);
      end else if (fill == 0) begin
        r.status = rbeo_pkg::ST_EMPTY;
      end else begin
        // first occupied slot at or after the take pointer
        s = take_ptr;
        for (int k = 0; k < SLOTS && !occupied[s]; k++) s = (s + 1) % SLOTS;
        r.status = rbeo_pkg::ST_TAKEN;
        r.request_id = slot_ids[s];
        r.creation_time = slot_stamps[s];
        r.slot_index = IX_W'(s);
        occupied[s] = 1'b0;
        take_ptr = (s + 1) % SLOTS;
      end
      fill = fill_level();
      r.now_full = (fill == SLOTS);
      r.now_empty = (fill == 0);
      pending_results = {pending_results, r};
    endfunction

    // compare one result beat with the oldest prediction
    function void check_beat(input ring_result_t got);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.request_id !== want.request_id) begin
        $error("request_id: expected %h, actual %h", want.request_id, got.request_id);
        error_count++;
      end
      if (got.creation_time !== want.creation_time) begin
        $error("creation_time: expected %h, actual %h",
               want.creation_time, got.creation_time);
        error_count++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
        error_count++;
      end
      if (got.now_full !== want.now_full) begin
        $error("now_full: expected %b, actual %b", want.now_full, got.now_full);
        error_count++;
      end
      if (got.now_empty !== want.now_empty) begin
        $error("now_empty: expected %b, actual %b", want.now_empty, got.now_empty);
        error_count++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_mode = rbeo_pkg::MODE_PLACE;
  logic [ID_W-1:0] in_request_id = '0;
  logic [TM_W-1:0] in_creation_time = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [ID_W-1:0] out_request_id;
  logic [TM_W-1:0] out_creation_time;
  logic [IX_W-1:0] out_slot_index;
  logic            out_now_full;
  logic            out_now_empty;

  request_ring_board board = new();
  bit                quiet = 1'b0;
  int unsigned       cycles = 0;

  ring_buffer_evict_oldest_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_request_id    (in_request_id),
    .in_creation_time (in_creation_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_request_id   (out_request_id),
    .out_creation_time(out_creation_time),
    .out_slot_index   (out_slot_index),
    .out_now_full     (out_now_full),
    .out_now_empty    (out_now_empty)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_beat({out_status, out_request_id, out_creation_time,
                        out_slot_index, out_now_full, out_now_empty});
    end
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);
  end

  // drive one input beat, with optional idle cycles first, and wait for accept
  task automatic send_op(input logic mode, input logic [ID_W-1:0] id,
                         input logic [TM_W-1:0] stamp);
    while (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      in_mode <= 1'($urandom);
      in_request_id <= ID_W'($urandom);
      in_creation_time <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_request_id <= id;
    in_creation_time <= stamp;
    do @(posedge clk); while (!in_ready);
    board.note_beat(mode, id, stamp);
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned     sent;
    int unsigned     burst;
    int unsigned     place_pct;
    logic            mode;
    logic [TM_W-1:0] stamp;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: take while empty, extremes, wrap, evictions with ties, drain
    send_op(rbeo_pkg::MODE_TAKE, 16'h1234, 32'h0);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0000, 32'hFFFF_FFFF);
    send_op(rbeo_pkg::MODE_PLACE, 16'hFFFF, 32'h0000_0000);
    send_op(rbeo_pkg::MODE_TAKE, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0102, 32'd100);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0103, 32'd7);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0104, 32'd7);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0105, 32'd9);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0106, 32'hFFFF_FFFF);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0107, 32'd7);
    send_op(rbeo_pkg::MODE_PLACE, 16'h0100, 32'd50);
    send_op(rbeo_pkg::MODE_PLACE, 16'hA001, 32'd7);
    send_op(rbeo_pkg::MODE_PLACE, 16'hA002, 32'h8000_0000);
    send_op(rbeo_pkg::MODE_PLACE, 16'hA003, 32'hFFFF_FFFE);
    repeat (SLOTS) send_op(rbeo_pkg::MODE_TAKE, 16'h0, 32'h0);
    send_op(rbeo_pkg::MODE_TAKE, 16'hFFFF, 32'hFFFF_FFFF);
    drain_results();

    // random bursts with a varying place/take mix so the ring fills and empties
    sent = 0;
    while (sent < RAND_BEATS) begin
      burst = $urandom_range(40, 10);
      case ($urandom_range(3))
        0:       place_pct = 10;
        1:       place_pct = 50;
        2:       place_pct = 75;
        default: place_pct = 92;
      endcase
      for (int b = 0; b < burst; b++) begin
        quiet = (sent >= 150 && sent < 300);
        if (sent == 250) drain_results();
        mode = ($urandom_range(99) < place_pct) ? rbeo_pkg::MODE_PLACE
                                                : rbeo_pkg::MODE_TAKE;
        // narrow stamps force ties, some land on the extremes
        case ($urandom_range(7))
          0, 1:    stamp = $urandom_range(15);
          2:       stamp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
          default: stamp = $urandom;
        endcase
        send_op(mode, ID_W'($urandom), stamp);
        sent++;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // wait out the last results, then let the clock run on to catch strays
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 4) @(posedge clk);
    if (board.error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/rbeo_pkg.sv
rtl/core/rbeo_cell.sv
rtl/core/ring_buffer_evict_oldest_core.sv
dv/tb.sv
